/* sv/dcfpw_pkg.sv */
// dcfpw_pkg: shared types and constants for the pulse-width bit decoder
// holds register indexes, reset values, the config bundle and the result bundle
// no dependencies
package dcfpw_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 10;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   typedef logic [CsrDataWidth-1:0]  csr_data_type;

   localparam csr_index_type CSR_STARTUP_WAIT        = 3'd0;
   localparam csr_index_type CSR_CARRIER_STUCK_LIMIT = 3'd1;
   localparam csr_index_type CSR_MINUTE_GAP_LIMIT    = 3'd2;
   localparam csr_index_type CSR_BAD_PULSE_LIMIT     = 3'd3;
   localparam csr_index_type CSR_ONE_PULSE_LIMIT     = 3'd4;

   localparam logic [7:0] STARTUP_WAIT_RESET        = 8'd10;
   localparam logic [7:0] CARRIER_STUCK_LIMIT_RESET = 8'd50;
   localparam logic [9:0] MINUTE_GAP_LIMIT_RESET    = 10'd120;
   localparam logic [7:0] BAD_PULSE_LIMIT_RESET     = 8'd60;
   localparam logic [7:0] ONE_PULSE_LIMIT_RESET     = 8'd15;

   typedef struct packed {
      logic [7:0] startup_wait;
      logic [7:0] carrier_stuck_limit;
      logic [9:0] minute_gap_limit;
      logic [7:0] bad_pulse_limit;
      logic [7:0] one_pulse_limit;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       bit_valid;
      logic       bit_value;
      logic [7:0] second_index;
      logic       minute_mark;
   } result_type;

endpackage

/* sv/dcf77_pulse_width_bit_decoder.sv */
// dcf77_pulse_width_bit_decoder: top level, input register, decoder core, result register
// depends on dcfpw_pkg, dcfpw_csr and dcfpw_core
//
// Usage:
//   req_ channel carries one carrier sample per transaction (valid/ready).
//   rsp_ channel carries a decoded bit and/or a minute mark; a sample that
//   decodes to nothing produces no rsp transaction at all.
//   csr_ port writes the five limit registers by index; write only while idle.
// Pipeline: a sample sits in the input register and is decoded by
//   the core on the edge that moves it into the result register, which
//   drives the rsp_ outputs; a stalled result register holds it back.
// Throughput: one sample per cycle while rsp_ready keeps the result register
//   draining; the core updates its run counters and tracking flag per sample.
// Reset: synchronous, active high; clears tracking, all counters, both
//   pipeline valids, and loads the default limits.
// Stall: while rsp_ready is low with a result held, the input register keeps
//   its sample and req_ready drops once that register is full.
module dcf77_pulse_width_bit_decoder
   import dcfpw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_sample,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_bit_valid,
   output logic          rsp_bit_value,
   output logic [7:0]    rsp_second_index,
   output logic          rsp_minute_mark,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_write_data
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_sample_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       advance;

   dcfpw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   dcfpw_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .sample (in_sample_ff),
      .cfg    (cfg),
      .result (result)
   );

   // the held sample moves through the core when the result register has room
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_bit_valid    = out_ff.bit_valid;
   assign rsp_bit_value    = out_ff.bit_value;
   assign rsp_second_index = out_ff.second_index;
   assign rsp_minute_mark  = out_ff.minute_mark;

endmodule

/* sv/dcfpw_csr.sv */
// dcfpw_csr: configuration register file, write-only
// depends on dcfpw_pkg for register indexes, reset values and cfg_type
module dcfpw_csr
   import dcfpw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_write_data,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STARTUP_WAIT:        cfg_in.startup_wait        = csr_write_data[7:0];
            CSR_CARRIER_STUCK_LIMIT: cfg_in.carrier_stuck_limit = csr_write_data[7:0];
            CSR_MINUTE_GAP_LIMIT:    cfg_in.minute_gap_limit    = csr_write_data[9:0];
            CSR_BAD_PULSE_LIMIT:     cfg_in.bad_pulse_limit     = csr_write_data[7:0];
            CSR_ONE_PULSE_LIMIT:     cfg_in.one_pulse_limit     = csr_write_data[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_wait        <= STARTUP_WAIT_RESET;
         cfg_ff.carrier_stuck_limit <= CARRIER_STUCK_LIMIT_RESET;
         cfg_ff.minute_gap_limit    <= MINUTE_GAP_LIMIT_RESET;
         cfg_ff.bad_pulse_limit     <= BAD_PULSE_LIMIT_RESET;
         cfg_ff.one_pulse_limit     <= ONE_PULSE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/dcfpw_core.sv */
// dcfpw_core: tracking state, run counters and pulse classification
// depends on dcfpw_pkg for cfg_type and result_type
module dcfpw_core
   import dcfpw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  logic       sample,
   input  cfg_type    cfg,
   output result_type result
);

   logic       tracking_ff, tracking_in;
   logic [7:0] startup_count_ff, startup_count_in;
   logic [7:0] high_run_ff, high_run_in;
   logic [9:0] low_run_ff, low_run_in;
   logic       previous_sample_ff, previous_sample_in;
   logic [7:0] second_count_ff, second_count_in;

   logic [7:0] high_run_inc;
   logic [9:0] low_run_inc;

   assign high_run_inc = high_run_ff + 8'd1;
   assign low_run_inc  = low_run_ff + 10'd1;

   always_comb begin
      tracking_in        = tracking_ff;
      startup_count_in   = startup_count_ff;
      high_run_in        = high_run_ff;
      low_run_in         = low_run_ff;
      second_count_in    = second_count_ff;
      previous_sample_in = sample;
      result             = '0;

      if (!tracking_ff) begin
         if (sample) begin
            if (startup_count_ff < cfg.startup_wait) begin
               startup_count_in = startup_count_ff + 8'd1;
            end else begin
               tracking_in = 1'b1;
            end
         end
      end else if (sample) begin
         low_run_in = '0;
         if (high_run_inc >= cfg.carrier_stuck_limit) begin
            high_run_in = '0;
            tracking_in = 1'b0;
         end else begin
            high_run_in = high_run_inc;
         end
      end else begin
         // minute clear comes before the bit, so a bit in the same tick lands at second 0
         low_run_in = low_run_inc;
         if (low_run_inc >= cfg.minute_gap_limit) begin
            low_run_in         = '0;
            second_count_in    = '0;
            result.minute_mark = 1'b1;
         end
         if (previous_sample_ff) begin
            if (high_run_ff >= cfg.bad_pulse_limit) begin
               tracking_in = 1'b0;
            end else begin
               result.bit_valid    = 1'b1;
               result.bit_value    = (high_run_ff >= cfg.one_pulse_limit);
               result.second_index = second_count_in;
               second_count_in     = second_count_in + 8'd1;
            end
            high_run_in = '0;
         end
      end

      result.valid = result.bit_valid | result.minute_mark;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff        <= 1'b0;
         startup_count_ff   <= '0;
         high_run_ff        <= '0;
         low_run_ff         <= '0;
         previous_sample_ff <= 1'b0;
         second_count_ff    <= '0;
      end else if (enable) begin
         tracking_ff        <= tracking_in;
         startup_count_ff   <= startup_count_in;
         high_run_ff        <= high_run_in;
         low_run_ff         <= low_run_in;
         previous_sample_ff <= previous_sample_in;
         second_count_ff    <= second_count_in;
      end
   end

endmodule

/* sv/dcfpw_checker.sv */
// dcfpw_checker: port-level assertions for the pulse-width bit decoder
// depends on dcf77_pulse_width_bit_decoder ports; bound to the top level below
module dcfpw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_bit_valid,
   input logic       rsp_bit_value,
   input logic [7:0] rsp_second_index,
   input logic       rsp_minute_mark
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bit_valid)
         && $stable(rsp_bit_value) && $stable(rsp_second_index)
         && $stable(rsp_minute_mark))
      else $error("rsp transaction changed while stalled");

   // a transaction always carries an event
   a_rsp_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bit_valid || rsp_minute_mark)
      else $error("empty rsp transaction");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bit_valid |-> !rsp_bit_value && rsp_second_index == 8'd0)
      else $error("bit fields not zero without a bit");

   // minute clear precedes the bit in the same sample
   a_mark_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bit_valid && rsp_minute_mark |-> rsp_second_index == 8'd0)
      else $error("bit with minute mark not at second zero");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind dcf77_pulse_width_bit_decoder dcfpw_checker u_dcfpw_checker (.*);
